/* rtl/core/lpve_pkg.sv */
// shared types, codes and constants for the line prefix value extractor
// no dependencies; used by every module of the block by scoped name
package lpve_pkg;

  // value store capacity; the usable length limit is one less, capped by the 6-bit count
  localparam int unsigned VALUE_CAPACITY = 64;
  localparam logic [5:0]  LIMIT_CAP      = (VALUE_CAPACITY - 1 > 63) ? 6'd63
                                           : 6'(VALUE_CAPACITY - 1);

  // key text "    dataDir=" and line characters
  localparam logic [5:0] KEY_LEN = 6'd12;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;

  // reset value of the length limit register
  localparam logic [5:0] MAX_LEN_RESET = 6'd63;

  // command codes
  localparam logic CMD_DATA    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // result status codes
  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_BYTE    = 3'd1;
  localparam logic [2:0] ST_DONE    = 3'd2;
  localparam logic [2:0] ST_ERROR   = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  // input word
  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] value_byte;
    logic [5:0] value_length;
  } out_word_t;

  // character of the key at a given index
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0, 4'd1, 4'd2, 4'd3: ch = 8'h20; // space
      4'd4:    ch = 8'h64; // d
      4'd5:    ch = 8'h61; // a
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h61; // a
      4'd8:    ch = 8'h44; // D
      4'd9:    ch = 8'h69; // i
      4'd10:   ch = 8'h72; // r
      4'd11:   ch = 8'h3D; // =
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/core/lpve_in_stage.sv */
// input register stage: holds one accepted word until the matcher takes it
// depends on lpve_pkg for the input word type
module lpve_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lpve_pkg::in_word_t in_data,
  input  logic               take,
  output logic               hold_valid,
  output lpve_pkg::in_word_t hold_word
);

  logic               valid_r;
  logic               valid_nxt;
  lpve_pkg::in_word_t word_r;
  logic               accept;

  // stall only while a held word cannot move on
  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  // occupancy of the stage
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_data;
    end
  end

  assign hold_valid = valid_r;
  assign hold_word  = word_r;

endmodule

/* rtl/core/lpve_match.sv */
// key matcher and value capture: mode and position state, result of one word
// depends on lpve_pkg for word types, key text and status codes
module lpve_match (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  lpve_pkg::in_word_t  word,
  input  logic [5:0]          max_len,
  output lpve_pkg::out_word_t result
);

  localparam logic [1:0] MODE_KEY      = 2'd0;
  localparam logic [1:0] MODE_SKIP     = 2'd1;
  localparam logic [1:0] MODE_VALUE    = 2'd2;
  localparam logic [1:0] MODE_FINISHED = 2'd3;

  logic [1:0] mode_r;
  logic [1:0] mode_nxt;
  logic [5:0] pos_r;
  logic [5:0] pos_nxt;
  logic [5:0] limit;
  logic       key_hit;
  logic [7:0] c;

  assign c       = word.data_byte;
  assign limit   = (max_len < lpve_pkg::LIMIT_CAP) ? max_len : lpve_pkg::LIMIT_CAP;
  assign key_hit = (pos_r < lpve_pkg::KEY_LEN) && (c == lpve_pkg::key_char(pos_r[3:0]));

  // next state and result of the current word
  always_comb begin
    mode_nxt            = mode_r;
    pos_nxt             = pos_r;
    result.status       = lpve_pkg::ST_BUSY;
    result.value_byte   = 8'h00;
    result.value_length = 6'd0;
    if (word.command == lpve_pkg::CMD_RESTART) begin
      mode_nxt = MODE_KEY;
      pos_nxt  = 6'd0;
    end else begin
      unique case (mode_r)
        MODE_KEY: begin
          if (key_hit) begin
            if (pos_r + 6'd1 == lpve_pkg::KEY_LEN) begin
              mode_nxt = MODE_VALUE;
              pos_nxt  = 6'd0;
            end else begin
              pos_nxt = pos_r + 6'd1;
            end
          end else begin
            mode_nxt = MODE_SKIP;
          end
        end
        MODE_SKIP: begin
          if (c == lpve_pkg::CH_LF) begin
            mode_nxt = MODE_KEY;
            pos_nxt  = 6'd0;
          end
        end
        MODE_VALUE: begin
          if (c == lpve_pkg::CH_CR) begin
            result.status       = lpve_pkg::ST_DONE;
            result.value_length = pos_r;
            mode_nxt            = MODE_FINISHED;
          end else if (pos_r < limit) begin
            pos_nxt             = pos_r + 6'd1;
            result.status       = lpve_pkg::ST_BYTE;
            result.value_byte   = c;
            result.value_length = pos_r + 6'd1;
          end else begin
            result.status       = lpve_pkg::ST_ERROR;
            result.value_length = pos_r;
            mode_nxt            = MODE_FINISHED;
          end
        end
        MODE_FINISHED: begin
          result.status = lpve_pkg::ST_IGNORED;
        end
        default: begin
          mode_nxt = MODE_KEY;
        end
      endcase
    end
  end

  // state moves only when a word is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_KEY;
      pos_r  <= 6'd0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // restart always lands at line start with a cleared position
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (word.command == lpve_pkg::CMD_RESTART)
    |=> (mode_r == MODE_KEY) && (pos_r == 6'd0))
    else $error("restart did not clear matcher state");

  // key index never runs past the key
  a_key_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_KEY) |-> (pos_r < lpve_pkg::KEY_LEN))
    else $error("key position out of range");

  // finished stays finished until a restart
  a_finished: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (mode_r == MODE_FINISHED) && (word.command == lpve_pkg::CMD_DATA)
    |=> (mode_r == MODE_FINISHED))
    else $error("left finished mode without restart");

  // no word consumed, no state change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(mode_r) && $stable(pos_r))
    else $error("matcher state changed without a word");

endmodule

/* rtl/core/line_prefix_value_extractor.sv */
// top level of the line prefix value extractor: length limit register,
// output register and handshake; uses lpve_pkg, lpve_in_stage, lpve_match
//
// usage:
//   input channel  in_valid / in_stall / in_data (command, data_byte): one
//     text byte or a restart command per word
//   result channel out_valid / out_stall / out_data (status, value_byte,
//     value_length): exactly one result word per input word, in order
//   cfg_we / cfg_wdata write the 6-bit value length limit; write only while
//     no word is in flight
//   latency: a word accepted at one clock edge sits in the input stage, its
//     result shows on out_data after the next edge and can be taken at the
//     edge after that (two register stages)
//   throughput: one word per cycle; the only loop is the one-cycle
//     mode/position update in the matcher
//   reset (rst_n low, synchronous): both stages empty, matcher looks for the
//     key at line start, limit back to 63
//   receiver stall: the result word holds; the input stage still takes one
//     word, then in_stall rises until the result is taken
module line_prefix_value_extractor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpve_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lpve_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_wdata
);

  logic [5:0]          limit_r;
  logic                hold_valid;
  lpve_pkg::in_word_t  hold_word;
  logic                take;
  lpve_pkg::out_word_t result;
  logic                out_valid_r;
  logic                out_valid_nxt;
  lpve_pkg::out_word_t out_data_r;

  // length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= lpve_pkg::MAX_LEN_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // held word moves on when the output register is free or being emptied
  assign take = hold_valid && (!out_valid_r || !out_stall);

  lpve_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_word  (hold_word)
  );

  lpve_match u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (take),
    .word    (hold_word),
    .max_len (limit_r),
    .result  (result)
  );

  // output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* tb/sv/tb_line_prefix_value_extractor.sv */
`timescale 1ns / 100ps
// testbench for line_prefix_value_extractor: sends text bytes and restarts,
// predicts each result word with its own key matcher and checks it in order
// depends on lpve_pkg and the rtl of the block only
module tb_line_prefix_value_extractor;

  localparam logic [95:0] KEY_TEXT = "    dataDir=";

  typedef enum logic [1:0] {SCAN_KEY, SCAN_SKIP, SCAN_VALUE, SCAN_FINISHED} scan_mode_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  lpve_pkg::in_word_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  lpve_pkg::out_word_t out_data;
  logic                cfg_we    = 1'b0;
  logic [5:0]          cfg_wdata = '0;

  // matcher state as the testbench sees it
  scan_mode_t scan_mode = SCAN_KEY;
  logic [5:0] scan_pos  = '0;
  logic [5:0] limit_reg = lpve_pkg::MAX_LEN_RESET;

  lpve_pkg::out_word_t result_words_due [$];
  lpve_pkg::out_word_t want;
  int mismatches = 0, words_checked = 0, values_done = 0, values_errored = 0;
  int words_sent = 0, active_words = 0;
  int in_idle_pct = 20, stall_pct = 20, stall_run = 0;

  line_prefix_value_extractor u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] key_byte(input int idx);
    return KEY_TEXT[95 - 8*idx -: 8];
  endfunction

  // mostly short pauses, now and then a long one
  function automatic int pause_length();
    return ($urandom_range(9) == 0) ? int'($urandom_range(8, 40)) : int'($urandom_range(1, 3));
  endfunction

  function automatic logic [7:0] random_byte_except(input logic [7:0] avoid);
    logic [7:0] r;
    r = 8'($urandom_range(255));
    while (r == avoid) r = 8'($urandom_range(255));
    return r;
  endfunction

  // one step of the extractor: updates the local state, returns the result word
  function automatic lpve_pkg::out_word_t extract_step(input logic cmd, input logic [7:0] ch);
    lpve_pkg::out_word_t res;
    logic [5:0]          lim;
    res = '0;
    res.status = lpve_pkg::ST_BUSY;
    lim = (limit_reg < lpve_pkg::LIMIT_CAP) ? limit_reg : lpve_pkg::LIMIT_CAP;
    if (cmd == lpve_pkg::CMD_RESTART) begin
      scan_mode = SCAN_KEY;
      scan_pos  = '0;
    end else begin
      case (scan_mode)
        SCAN_KEY: begin
          if (scan_pos < lpve_pkg::KEY_LEN && ch == key_byte(scan_pos)) begin
            scan_pos = scan_pos + 6'd1;
            if (scan_pos == lpve_pkg::KEY_LEN) begin
              scan_mode = SCAN_VALUE;
              scan_pos  = '0;
            end
          end else begin
            scan_mode = SCAN_SKIP;
          end
        end
        SCAN_SKIP: begin
          if (ch == lpve_pkg::CH_LF) begin
            scan_mode = SCAN_KEY;
            scan_pos  = '0;
          end
        end
        SCAN_VALUE: begin
          if (ch == lpve_pkg::CH_CR) begin
            res.status       = lpve_pkg::ST_DONE;
            res.value_length = scan_pos;
            scan_mode        = SCAN_FINISHED;
          end else if (scan_pos < lim) begin
            scan_pos         = scan_pos + 6'd1;
            res.status       = lpve_pkg::ST_BYTE;
            res.value_byte   = ch;
            res.value_length = scan_pos;
          end else begin
            res.status       = lpve_pkg::ST_ERROR;
            res.value_length = scan_pos;
            scan_mode        = SCAN_FINISHED;
          end
        end
        default: res.status = lpve_pkg::ST_IGNORED;
      endcase
    end
    return res;
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_run <= pause_length() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic note_mismatch(input string what, input lpve_pkg::out_word_t exp_word);
    if (mismatches < 10)
      $display("%0t: %s: expected status/byte/length %0d/%02h/%0d, got %0d/%02h/%0d",
               $realtime, what, exp_word.status, exp_word.value_byte, exp_word.value_length,
               out_data.status, out_data.value_byte, out_data.value_length);
    mismatches++;
  endtask

  // compare every result word taken with the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      words_checked++;
      if (out_data.status == lpve_pkg::ST_DONE) values_done++;
      if (out_data.status == lpve_pkg::ST_ERROR) values_errored++;
      if (result_words_due.size() == 0) begin
        note_mismatch("result word with none due", '0);
      end else begin
        want = result_words_due.pop_front();
        if (out_data.status !== want.status || out_data.value_byte !== want.value_byte ||
            out_data.value_length !== want.value_length)
          note_mismatch("result word differs", want);
      end
    end
  end

  // send one word, at times after a random pause, predict its result once taken
  task automatic send_word(input logic cmd, input logic [7:0] ch);
    int                  gap;
    lpve_pkg::out_word_t res;
    gap = ($urandom_range(99) < in_idle_pct) ? pause_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {cmd, ch};
    do @(posedge clk); while (in_stall !== 1'b0);
    res = extract_step(cmd, ch);
    result_words_due.push_back(res);
    words_sent++;
    if (res.status != lpve_pkg::ST_IGNORED) active_words++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (result_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [5:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_reg = v;
  endtask

  task automatic send_key(input int n);
    for (int i = 0; i < n; i++) send_word(lpve_pkg::CMD_DATA, key_byte(i));
  endtask

  task automatic send_value_bytes(input int n);
    repeat (n) send_word(lpve_pkg::CMD_DATA, random_byte_except(lpve_pkg::CH_CR));
  endtask

  // key then a value with both byte extremes and a newline, closed by cr
  task automatic test_key_match();
    send_key(lpve_pkg::KEY_LEN);
    send_word(lpve_pkg::CMD_DATA, 8'h00);
    send_word(lpve_pkg::CMD_DATA, 8'hFF);
    send_word(lpve_pkg::CMD_DATA, lpve_pkg::CH_LF);
    send_word(lpve_pkg::CMD_DATA, lpve_pkg::CH_CR);
    send_word(lpve_pkg::CMD_DATA, 8'h7A);
  endtask

  // restart from finished, mismatch and skip, newline at line start, restart mid key
  task automatic test_restart_and_skip();
    send_word(lpve_pkg::CMD_RESTART, 8'hA5);
    send_word(lpve_pkg::CMD_DATA, 8'h20);
    send_word(lpve_pkg::CMD_DATA, 8'h78);
    send_word(lpve_pkg::CMD_DATA, 8'h20);
    send_word(lpve_pkg::CMD_DATA, lpve_pkg::CH_LF);
    send_word(lpve_pkg::CMD_DATA, lpve_pkg::CH_LF);
    send_word(lpve_pkg::CMD_DATA, lpve_pkg::CH_LF);
    send_key(6);
    send_word(lpve_pkg::CMD_RESTART, 8'h00);
  endtask

  // limit register at zero, one and the top
  task automatic test_limit_extremes();
    set_limit(6'd0);
    send_key(lpve_pkg::KEY_LEN);
    send_word(lpve_pkg::CMD_DATA, 8'h61);
    send_word(lpve_pkg::CMD_DATA, 8'h62);
    send_word(lpve_pkg::CMD_RESTART, 8'hFF);
    send_key(lpve_pkg::KEY_LEN);
    send_word(lpve_pkg::CMD_DATA, lpve_pkg::CH_CR);
    set_limit(6'd1);
    send_word(lpve_pkg::CMD_RESTART, 8'h00);
    send_key(lpve_pkg::KEY_LEN);
    send_value_bytes(2);
    set_limit(6'd63);
    send_word(lpve_pkg::CMD_RESTART, 8'h00);
    send_key(lpve_pkg::KEY_LEN);
    send_value_bytes(64);
    send_word(lpve_pkg::CMD_RESTART, 8'h00);
  endtask

  // well-formed line with random junk lines ahead and a random value length
  task automatic send_record();
    int lim_now, len, k;
    lim_now = (limit_reg < lpve_pkg::LIMIT_CAP) ? limit_reg : lpve_pkg::LIMIT_CAP;
    send_word(lpve_pkg::CMD_RESTART, 8'($urandom_range(255)));
    k = ($urandom_range(3) == 0) ? int'($urandom_range(1, 2)) : 0;
    repeat (k) begin
      repeat ($urandom_range(0, 6))
        send_word(lpve_pkg::CMD_DATA, random_byte_except(lpve_pkg::CH_LF));
      send_word(lpve_pkg::CMD_DATA, lpve_pkg::CH_LF);
    end
    case ($urandom_range(9))
      0:       len = 0;
      1:       len = lim_now;
      2:       len = lim_now + 1;
      default: len = $urandom_range(0, (lim_now < 10) ? lim_now : 10);
    endcase
    send_key(lpve_pkg::KEY_LEN);
    send_value_bytes((len > lim_now) ? lim_now + 1 : len);
    if (len <= lim_now) send_word(lpve_pkg::CMD_DATA, lpve_pkg::CH_CR);
    // trailing bytes after done or error are ignored
    repeat ($urandom_range(0, 2)) send_word(lpve_pkg::CMD_DATA, 8'($urandom_range(255)));
  endtask

  // bytes biased towards spaces and line ends, with the odd restart
  task automatic send_noise();
    repeat ($urandom_range(5, 30)) begin
      case ($urandom_range(19))
        0:                 send_word(lpve_pkg::CMD_RESTART, 8'($urandom_range(255)));
        1, 2:              send_word(lpve_pkg::CMD_DATA, lpve_pkg::CH_LF);
        3, 4:              send_word(lpve_pkg::CMD_DATA, lpve_pkg::CH_CR);
        5, 6, 7, 8, 9, 10: send_word(lpve_pkg::CMD_DATA, 8'h20);
        default:           send_word(lpve_pkg::CMD_DATA, 8'($urandom_range(255)));
      endcase
    end
  endtask

  // key broken at a random position, then rest of the line
  task automatic send_broken_key();
    int k;
    k = $urandom_range(0, lpve_pkg::KEY_LEN - 1);
    send_word(lpve_pkg::CMD_RESTART, 8'($urandom_range(255)));
    send_key(k);
    send_word(lpve_pkg::CMD_DATA, random_byte_except(key_byte(k)));
    repeat ($urandom_range(0, 4))
      send_word(lpve_pkg::CMD_DATA, random_byte_except(lpve_pkg::CH_LF));
    if ($urandom_range(1)) send_word(lpve_pkg::CMD_DATA, lpve_pkg::CH_LF);
  endtask

  // value cut short by a restart
  task automatic send_cut_record();
    send_word(lpve_pkg::CMD_RESTART, 8'($urandom_range(255)));
    send_key(lpve_pkg::KEY_LEN);
    send_value_bytes($urandom_range(0, 3));
    send_word(lpve_pkg::CMD_RESTART, 8'($urandom_range(255)));
  endtask

  task automatic test_random_records(input logic [5:0] lim, input int target, input int idle,
                                     input int stall);
    int base;
    set_limit(lim);
    in_idle_pct = idle;
    stall_pct   = stall;
    base        = active_words;
    while (active_words - base < target) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: send_record();
        6, 7:             send_noise();
        8:                send_broken_key();
        default:          send_cut_record();
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_key_match();
    test_restart_and_skip();
    test_limit_extremes();
    test_random_records(6'd63, 250, 30, 30);
    test_random_records(6'd5, 250, 0, 0);
    test_random_records(6'd1, 120, 50, 50);
    test_random_records(6'd0, 80, 25, 25);
    test_random_records(6'($urandom_range(2, 62)), 300, 40, 15);
    wait_idle();
    $display("run covered %0d input words, %0d result words checked, %0d mismatches",
             words_sent, words_checked, mismatches);
    $display("values closed by cr: %0d, values over the limit: %0d",
             values_done, values_errored);
    if (mismatches == 0 && result_words_due.size() == 0) begin
      $display("[line_prefix_value_extractor] OK");
    end else begin
      $display("[line_prefix_value_extractor] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("timeout with %0d result words still due", result_words_due.size());
    $display("[line_prefix_value_extractor] ERROR");
    $finish;
  end

endmodule
